// File: rtl/ufrs_pkg.sv
// Shared types, codes and register-map constants of the UART framed register slave.
package ufrs_pkg;

	localparam int NUM_WORDS = 15;
	localparam int SLOT_W    = $clog2(NUM_WORDS);

	typedef logic [7:0]        byte_t;
	typedef logic [15:0]       word_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [6:0]        regaddr_t;

	typedef word_t [0:NUM_WORDS-1] rfile_t;
	typedef byte_t [0:NUM_WORDS-1] amap_t;

	// Address lookup result
	typedef struct packed {
		logic  hit;
		slot_t slot;
	} lookup_t;

	// Input action codes
	localparam logic ACT_UART   = 1'b0;
	localparam logic ACT_DIRECT = 1'b1;

	// Result kind codes
	localparam logic KIND_UART   = 1'b0;
	localparam logic KIND_DIRECT = 1'b1;

	// Direct write status codes
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_UNKNOWN = 1'b1;

	// Framing constants
	localparam byte_t    SOF_BYTE        = 8'hFE;
	localparam word_t    SOFT_RESET_WORD = 16'h789A;
	localparam regaddr_t ADDR_RESET      = 7'h00;
	localparam regaddr_t ADDR_SYSSTATUS  = 7'h01;
	localparam regaddr_t ADDR_APENERGY   = 7'h40;
	localparam slot_t    SLOT_LASTDATA   = 4'd3;

	// Register map: bus address of each slot
	localparam amap_t WORD_ADDR = '{
		8'h01, 8'h02, 8'h03, 8'h06, 8'h20, 8'h2B, 8'h30, 8'h40,
		8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h68
	};

	// Register map: reset value of each slot
	localparam rfile_t WORD_RESET = '{
		16'h0000, 16'h000C, 16'h1D6A, 16'h0000, 16'h6886, 16'h9422, 16'h6886, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd5000, 16'h0000, 16'h0000
	};

	// Map a bus address onto a register slot
	function automatic lookup_t find_slot(input byte_t a);
		lookup_t r;
		r = '0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			if (WORD_ADDR[i] == a) begin
				r.hit  = 1'b1;
				r.slot = slot_t'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/ufrs_if.sv
// Valid/ready channel interfaces for requests and results of the register slave.
interface ufrs_item_if;
	logic             valid;
	logic             ready;
	logic             action;
	ufrs_pkg::byte_t  rx_byte;
	ufrs_pkg::byte_t  reg_addr;
	ufrs_pkg::word_t  reg_value;

	modport source (output valid, output action, output rx_byte, output reg_addr,
		output reg_value, input ready);
	modport sink (input valid, input action, input rx_byte, input reg_addr,
		input reg_value, output ready);
endinterface

interface ufrs_result_if;
	logic             valid;
	logic             ready;
	logic             kind;
	ufrs_pkg::byte_t  tx_byte;
	logic             last;
	logic             set_status;

	modport source (output valid, output kind, output tx_byte, output last,
		output set_status, input ready);
	modport sink (input valid, input kind, input tx_byte, input last,
		input set_status, output ready);
endinterface

// File: rtl/uart_framed_register_slave_core.sv
// Top level of the UART framed register slave: frame parser, register file and result buffer.
//
// Each request is either one host UART byte or one direct register write, and is
// handled in the cycle it is accepted: the parser state and the 15-word register file
// update at that edge, and the results it causes are loaded into a three-entry result
// buffer. A frame that ends in a good read yields three bytes (MSB, LSB, their sum),
// a good write yields one ack byte, a direct write yields one status result, and all
// other bytes yield none. The buffer drains one result per cycle while the result channel
// is ready; a new request is taken whenever the buffer is empty or its final entry is
// being taken, so requests run at one per cycle while it is ready, except after a read,
// which holds requests until its first two bytes are taken. respond_enable is written
// through cfg_we/cfg_wdata; the user must write it only while the block is idle (the block
// does not enforce this); when low, complete frames have no effect but direct writes apply.
module uart_framed_register_slave_core (
	input  logic                 clk,
	input  logic                 arst_n,
	ufrs_item_if.sink            item,
	ufrs_result_if.source        result,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ADDR = 3'd1,
		PH_MSB  = 3'd2,
		PH_LSB  = 3'd3,
		PH_CHK  = 3'd4
	} phase_t;

	phase_t                     phase_q, phase_d;
	ufrs_pkg::byte_t            addr_q, addr_d;
	ufrs_pkg::byte_t            hi_q, hi_d;
	ufrs_pkg::byte_t            lo_q, lo_d;
	ufrs_pkg::rfile_t           rf_q, rf_d;
	logic                       resp_en_q;

	logic [1:0]                 cnt_q, cnt_d;
	ufrs_pkg::byte_t [0:2]      res_q, res_d;
	logic                       kind_q, kind_d;
	logic                       st_q, st_d;

	ufrs_pkg::lookup_t          lk_frame;
	ufrs_pkg::lookup_t          lk_direct;
	ufrs_pkg::word_t            rd_val;
	ufrs_pkg::word_t            wr_val;
	ufrs_pkg::byte_t            wr_sum;
	ufrs_pkg::regaddr_t         frame_reg;
	logic                       accept;
	logic                       drain;

	// Take a request when the result buffer is empty or about to be
	assign item.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && result.ready);
	assign accept     = item.valid && item.ready;
	assign drain      = result.valid && result.ready;

	assign result.valid      = (cnt_q != 2'd0);
	assign result.tx_byte    = res_q[0];
	assign result.kind       = kind_q;
	assign result.set_status = st_q;
	assign result.last       = (cnt_q == 2'd1);

	// Decode the request against the current parser and register state
	always_comb begin
		frame_reg = addr_q[6:0];
		lk_frame  = ufrs_pkg::find_slot({1'b0, frame_reg});
		lk_direct = ufrs_pkg::find_slot(item.reg_addr);
		rd_val    = lk_frame.hit ? rf_q[lk_frame.slot] : '0;
		wr_val    = {hi_q, lo_q};
		wr_sum    = addr_q + hi_q + lo_q;

		phase_d = phase_q;
		addr_d  = addr_q;
		hi_d    = hi_q;
		lo_d    = lo_q;
		rf_d    = rf_q;
		cnt_d   = 2'd0;
		res_d   = '0;
		kind_d  = ufrs_pkg::KIND_UART;
		st_d    = ufrs_pkg::ST_OK;

		if (item.action == ufrs_pkg::ACT_DIRECT) begin
			cnt_d  = 2'd1;
			kind_d = ufrs_pkg::KIND_DIRECT;
			if (item.reg_addr == {1'b0, ufrs_pkg::ADDR_RESET} &&
			    item.reg_value == ufrs_pkg::SOFT_RESET_WORD) begin
				rf_d    = ufrs_pkg::WORD_RESET;
				phase_d = PH_IDLE;
				addr_d  = '0;
				hi_d    = '0;
				lo_d    = '0;
			end else if (lk_direct.hit) begin
				rf_d[lk_direct.slot] = item.reg_value;
			end else begin
				st_d = ufrs_pkg::ST_UNKNOWN;
			end
		end else begin
			case (phase_q)
				PH_ADDR: begin
					addr_d  = item.rx_byte;
					phase_d = item.rx_byte[7] ? PH_CHK : PH_MSB;
				end
				PH_MSB: begin
					hi_d    = item.rx_byte;
					phase_d = PH_LSB;
				end
				PH_LSB: begin
					lo_d    = item.rx_byte;
					phase_d = PH_CHK;
				end
				PH_CHK: begin
					phase_d = PH_IDLE;
					if (addr_q[7]) begin
						// Read: answer the word, then clear status and energy
						if (item.rx_byte == addr_q && resp_en_q) begin
							rf_d[ufrs_pkg::SLOT_LASTDATA] = rd_val;
							if (lk_frame.hit && (frame_reg == ufrs_pkg::ADDR_SYSSTATUS ||
							    frame_reg == ufrs_pkg::ADDR_APENERGY)) begin
								rf_d[lk_frame.slot] = '0;
							end
							cnt_d    = 2'd3;
							res_d[0] = rd_val[15:8];
							res_d[1] = rd_val[7:0];
							res_d[2] = rd_val[15:8] + rd_val[7:0];
						end
					end else begin
						// Write: store, or soft reset, then ack
						if (item.rx_byte == wr_sum && resp_en_q) begin
							rf_d[ufrs_pkg::SLOT_LASTDATA] = wr_val;
							if (frame_reg == ufrs_pkg::ADDR_RESET &&
							    wr_val == ufrs_pkg::SOFT_RESET_WORD) begin
								rf_d   = ufrs_pkg::WORD_RESET;
								addr_d = '0;
								hi_d   = '0;
								lo_d   = '0;
							end else if (lk_frame.hit) begin
								rf_d[lk_frame.slot] = wr_val;
							end
							cnt_d    = 2'd1;
							res_d[0] = wr_sum;
						end
					end
				end
				default: begin
					phase_d = (item.rx_byte == ufrs_pkg::SOF_BYTE) ? PH_ADDR : PH_IDLE;
				end
			endcase
		end
	end

	// Hold parser state, register file, configuration and the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			addr_q    <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			rf_q      <= ufrs_pkg::WORD_RESET;
			resp_en_q <= 1'b1;
			cnt_q     <= 2'd0;
			res_q     <= '0;
			kind_q    <= ufrs_pkg::KIND_UART;
			st_q      <= ufrs_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				resp_en_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= phase_d;
				addr_q  <= addr_d;
				hi_q    <= hi_d;
				lo_q    <= lo_d;
				rf_q    <= rf_d;
				cnt_q   <= cnt_d;
				res_q   <= res_d;
				kind_q  <= kind_d;
				st_q    <= st_d;
			end else if (drain) begin
				// Advance the buffer by one entry
				cnt_q    <= cnt_q - 2'd1;
				res_q[0] <= res_q[1];
				res_q[1] <= res_q[2];
				res_q[2] <= '0;
			end
		end
	end

endmodule

// File: tb/uart_framed_register_slave_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UART framed register slave core: directed frames, then random traffic.
module uart_framed_register_slave_core_tb;

	// Frame parser position held by the predictor
	typedef enum logic [2:0] {FR_IDLE, FR_ADDR, FR_HIGH, FR_LOW, FR_CHECK} frame_step_t;

	typedef struct packed {
		logic            kind;
		ufrs_pkg::byte_t tx_byte;
		logic            last;
		logic            set_status;
	} reply_t;

	localparam int RAND_REQS     = 360;
	localparam int SETTLE_CYCLES = 4;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ufrs_item_if   item ();
	ufrs_result_if result ();

	uart_framed_register_slave_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state
	ufrs_pkg::word_t regs_m [ufrs_pkg::NUM_WORDS];
	frame_step_t     step_m;
	ufrs_pkg::byte_t addr_m;
	ufrs_pkg::byte_t high_m;
	ufrs_pkg::byte_t low_m;
	logic            respond_m;

	reply_t pending_replies [$];
	int     mismatches;
	int     useful_reqs;
	bit     gaps_on;
	bit     stalls_on;

	always #2 clk = ~clk;

	// Map a bus address onto a register slot, -1 when unmapped
	function automatic int slot_of(input ufrs_pkg::byte_t a);
		for (int i = 0; i < ufrs_pkg::NUM_WORDS; i++) begin
			if (ufrs_pkg::WORD_ADDR[i] == a)
				return i;
		end
		return -1;
	endfunction

	function automatic ufrs_pkg::regaddr_t pick_addr();
		if ($urandom_range(0, 9) < 7)
			return ufrs_pkg::WORD_ADDR[$urandom_range(0, ufrs_pkg::NUM_WORDS - 1)][6:0];
		return ufrs_pkg::regaddr_t'($urandom_range(0, 127));
	endfunction

	// Restore register defaults and idle the parser
	task automatic model_clear();
		for (int i = 0; i < ufrs_pkg::NUM_WORDS; i++)
			regs_m[i] = ufrs_pkg::WORD_RESET[i];
		step_m = FR_IDLE;
		addr_m = '0;
		high_m = '0;
		low_m  = '0;
	endtask

	task automatic push_reply(input logic kind, input ufrs_pkg::byte_t tx, input logic last,
			input logic st);
		pending_replies.push_back(reply_t'{kind: kind, tx_byte: tx, last: last,
			set_status: st});
	endtask

	// Advance the predictor by one accepted request and queue the replies it causes
	task automatic model_request(input logic act, input ufrs_pkg::byte_t rx,
			input ufrs_pkg::byte_t ra, input ufrs_pkg::word_t rv);
		int              s;
		ufrs_pkg::word_t v;
		ufrs_pkg::byte_t hi;
		ufrs_pkg::byte_t lo;
		ufrs_pkg::byte_t sum;
		if (act == ufrs_pkg::ACT_DIRECT) begin
			s = slot_of(ra);
			if (ra == {1'b0, ufrs_pkg::ADDR_RESET} && rv == ufrs_pkg::SOFT_RESET_WORD) begin
				model_clear();
				push_reply(ufrs_pkg::KIND_DIRECT, '0, 1'b1, ufrs_pkg::ST_OK);
			end else if (s >= 0) begin
				regs_m[s] = rv;
				push_reply(ufrs_pkg::KIND_DIRECT, '0, 1'b1, ufrs_pkg::ST_OK);
			end else begin
				push_reply(ufrs_pkg::KIND_DIRECT, '0, 1'b1, ufrs_pkg::ST_UNKNOWN);
			end
		end else begin
			case (step_m)
				FR_ADDR: begin
					addr_m = rx;
					step_m = rx[7] ? FR_CHECK : FR_HIGH;
				end
				FR_HIGH: begin
					high_m = rx;
					step_m = FR_LOW;
				end
				FR_LOW: begin
					low_m  = rx;
					step_m = FR_CHECK;
				end
				FR_CHECK: begin
					step_m = FR_IDLE;
					s = slot_of({1'b0, addr_m[6:0]});
					if (addr_m[7]) begin
						if (rx == addr_m && respond_m) begin
							v = (s >= 0) ? regs_m[s] : '0;
							regs_m[ufrs_pkg::SLOT_LASTDATA] = v;
							if (s >= 0 && (addr_m[6:0] == ufrs_pkg::ADDR_SYSSTATUS ||
									addr_m[6:0] == ufrs_pkg::ADDR_APENERGY))
								regs_m[s] = '0;
							hi  = v[15:8];
							lo  = v[7:0];
							sum = hi + lo;
							push_reply(ufrs_pkg::KIND_UART, hi, 1'b0, ufrs_pkg::ST_OK);
							push_reply(ufrs_pkg::KIND_UART, lo, 1'b0, ufrs_pkg::ST_OK);
							push_reply(ufrs_pkg::KIND_UART, sum, 1'b1, ufrs_pkg::ST_OK);
						end
					end else begin
						sum = addr_m + high_m + low_m;
						v   = {high_m, low_m};
						if (rx == sum && respond_m) begin
							regs_m[ufrs_pkg::SLOT_LASTDATA] = v;
							if (addr_m[6:0] == ufrs_pkg::ADDR_RESET &&
									v == ufrs_pkg::SOFT_RESET_WORD)
								model_clear();
							else if (s >= 0)
								regs_m[s] = v;
							push_reply(ufrs_pkg::KIND_UART, sum, 1'b1, ufrs_pkg::ST_OK);
						end
					end
				end
				default: begin
					step_m = (rx == ufrs_pkg::SOF_BYTE) ? FR_ADDR : FR_IDLE;
				end
			endcase
		end
	endtask

	// Drive one request and hold it until the block takes it
	task automatic send_req(input logic act, input ufrs_pkg::byte_t rx,
			input ufrs_pkg::byte_t ra, input ufrs_pkg::word_t rv);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item.valid     <= 1'b1;
		item.action    <= act;
		item.rx_byte   <= rx;
		item.reg_addr  <= ra;
		item.reg_value <= rv;
		do @(posedge clk); while (!item.ready);
		if (!(act == ufrs_pkg::ACT_UART && step_m == FR_IDLE && rx != ufrs_pkg::SOF_BYTE))
			useful_reqs++;
		model_request(act, rx, ra, rv);
	endtask

	task automatic send_byte(input ufrs_pkg::byte_t b);
		send_req(ufrs_pkg::ACT_UART, b, ufrs_pkg::byte_t'($urandom),
			ufrs_pkg::word_t'($urandom));
	endtask

	task automatic send_direct(input ufrs_pkg::byte_t ra, input ufrs_pkg::word_t rv);
		send_req(ufrs_pkg::ACT_DIRECT, ufrs_pkg::byte_t'($urandom), ra, rv);
	endtask

	task automatic send_read(input ufrs_pkg::regaddr_t a, input bit good);
		ufrs_pkg::byte_t ab;
		ab = {1'b1, a};
		send_byte(ufrs_pkg::SOF_BYTE);
		send_byte(ab);
		send_byte(good ? ab : ab ^ ufrs_pkg::byte_t'(1 << $urandom_range(0, 7)));
	endtask

	task automatic send_write(input ufrs_pkg::regaddr_t a, input ufrs_pkg::word_t v,
			input bit good);
		ufrs_pkg::byte_t sum;
		sum = {1'b0, a} + v[15:8] + v[7:0];
		send_byte(ufrs_pkg::SOF_BYTE);
		send_byte({1'b0, a});
		send_byte(v[15:8]);
		send_byte(v[7:0]);
		send_byte(good ? sum : sum ^ ufrs_pkg::byte_t'(1 << $urandom_range(0, 7)));
	endtask

	// Drop valid and wait for every queued reply, then let the block settle
	task automatic await_idle();
		item.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_respond(input logic en);
		await_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we    <= 1'b0;
		respond_m = en;
	endtask

	task automatic test_read_clear();
		send_direct({1'b0, ufrs_pkg::ADDR_SYSSTATUS}, 16'hFFFF);
		send_read(ufrs_pkg::ADDR_SYSSTATUS, 1'b1);
		send_read(ufrs_pkg::ADDR_SYSSTATUS, 1'b1);
	endtask

	task automatic test_write_ack();
		send_write(7'h02, 16'hFFFF, 1'b1);
		send_read(7'h7F, 1'b1);
	endtask

	task automatic test_bad_frames();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_read(7'h03, 1'b0);
		send_write(7'h03, 16'h0000, 1'b0);
	endtask

	task automatic test_soft_reset();
		// Soft reset by direct write in the middle of a frame
		send_byte(ufrs_pkg::SOF_BYTE);
		send_direct({1'b0, ufrs_pkg::ADDR_RESET}, ufrs_pkg::SOFT_RESET_WORD);
		send_direct(8'hFF, 16'h0000);
		send_write(ufrs_pkg::ADDR_RESET, ufrs_pkg::SOFT_RESET_WORD, 1'b1);
	endtask

	task automatic test_respond_off();
		set_respond(1'b0);
		send_read(7'h4C, 1'b1);
		send_direct(8'h4C, 16'h0001);
		set_respond(1'b1);
		send_read(7'h4C, 1'b1);
	endtask

	task automatic test_random();
		int                 target;
		int                 pick;
		bit                 paused;
		ufrs_pkg::regaddr_t a;
		ufrs_pkg::word_t    v;
		paused = 1'b0;
		for (int chunk = 0; chunk < 6; chunk++) begin
			case (chunk)
				2:       set_respond(1'b0);
				3:       set_respond(1'b1);
				4:       set_respond(logic'($urandom_range(0, 1)));
				5:       set_respond(1'b1);
				default: ;
			endcase
			gaps_on   = (chunk != 3) && (chunk != 5);
			stalls_on = (chunk != 1) && (chunk != 5);
			target    = useful_reqs + RAND_REQS / 6;
			while (useful_reqs < target) begin
				// Hold off the sender once until all replies are in
				if (chunk == 1 && !paused && useful_reqs > target - RAND_REQS / 12) begin
					await_idle();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 99);
				a    = pick_addr();
				v    = ufrs_pkg::word_t'($urandom);
				if (pick < 40) begin
					send_read(a, $urandom_range(0, 9) != 0);
				end else if (pick < 75) begin
					if ($urandom_range(0, 19) == 0) begin
						a = ufrs_pkg::ADDR_RESET;
						v = ufrs_pkg::SOFT_RESET_WORD;
					end
					send_write(a, v, $urandom_range(0, 9) != 0);
				end else if (pick < 88) begin
					if ($urandom_range(0, 29) == 0)
						send_direct({1'b0, ufrs_pkg::ADDR_RESET}, ufrs_pkg::SOFT_RESET_WORD);
					else if ($urandom_range(0, 4) < 3)
						send_direct({1'b0, a}, v);
					else
						send_direct(ufrs_pkg::byte_t'($urandom), v);
				end else if (pick < 94) begin
					send_byte(ufrs_pkg::byte_t'($urandom));
				end else begin
					// Broken frame: start and address, then random bytes
					send_byte(ufrs_pkg::SOF_BYTE);
					send_byte(ufrs_pkg::byte_t'($urandom));
					repeat ($urandom_range(0, 2)) send_byte(ufrs_pkg::byte_t'($urandom));
				end
				// Resync the parser before the next frame
				while (step_m != FR_IDLE)
					send_byte(ufrs_pkg::byte_t'($urandom));
			end
		end
	endtask

	// Result sink with random stall bursts
	initial begin : sink_pacing
		int hold;
		hold = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				result.ready <= 1'b0;
				hold--;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				result.ready <= 1'b0;
				hold = $urandom_range(0, 4);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// Compare each taken result with the oldest queued reply
	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result kind=%0d tx_byte=%02h last=%0d set_status=%0d",
					$time, result.kind, result.tx_byte, result.last, result.set_status);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				if (result.kind !== want.kind) begin
					$display("%0t: kind expected %0d, got %0d", $time, want.kind, result.kind);
					mismatches++;
				end
				if (result.tx_byte !== want.tx_byte) begin
					$display("%0t: tx_byte expected %02h, got %02h", $time, want.tx_byte,
						result.tx_byte);
					mismatches++;
				end
				if (result.last !== want.last) begin
					$display("%0t: last expected %0d, got %0d", $time, want.last, result.last);
					mismatches++;
				end
				if (result.set_status !== want.set_status) begin
					$display("%0t: set_status expected %0d, got %0d", $time, want.set_status,
						result.set_status);
					mismatches++;
				end
			end
		end
	end

	initial begin : run_tests
		clk            = 1'b0;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= 1'b0;
		item.valid     <= 1'b0;
		item.action    <= ufrs_pkg::ACT_UART;
		item.rx_byte   <= '0;
		item.reg_addr  <= '0;
		item.reg_value <= '0;
		mismatches  = 0;
		useful_reqs = 0;
		gaps_on     = 1'b1;
		stalls_on   = 1'b1;
		model_clear();
		respond_m = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_read_clear();
		test_write_ack();
		test_bad_frames();
		test_soft_reset();
		test_respond_off();
		test_random();

		// Drain outstanding replies
		item.valid <= 1'b0;
		for (int n = 0; n < 20000 && pending_replies.size() != 0; n++)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (pending_replies.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_replies.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("uart_framed_register_slave_core test passed");
		else
			$display("uart_framed_register_slave_core test failed");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin : watchdog
		#2000000;
		$display("uart_framed_register_slave_core test failed");
		$finish;
	end

endmodule
